// ----- hw/rtl/region_refinement_cell_size_top_assert.svh -----
// Assertion macros for the region refinement cell size block.
// Needs a clk and an active high rst in the scope of each use.
`ifndef REGION_REFINEMENT_CELL_SIZE_TOP_ASSERT_SVH
`define REGION_REFINEMENT_CELL_SIZE_TOP_ASSERT_SVH

// same-cycle implication
`define RRCS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RRCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/rrcs_pkg.sv -----
// Types and constants of the region refinement cell size block.
// No dependencies; used by rrcs_table and the top level.
`timescale 1ns / 1ps

package rrcs_pkg;

  localparam int COORD_BITS = 24;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] KIND_OFF   = 2'd0;
  localparam logic [1:0] KIND_SHELL = 2'd1;
  localparam logic [1:0] KIND_BOX   = 2'd2;

  localparam logic [31:0] SPACING_RESET = 32'h0001_0000;
  // floor(b/10) = (b * RECIP_10) >> RECIP_SHIFT for any 32-bit b
  localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic       opcode;
    logic [2:0] slot;
    logic [1:0] kind;
    coord_t     lo_x;
    coord_t     hi_x;
    coord_t     lo_y;
    coord_t     hi_y;
    coord_t     lo_z;
    coord_t     hi_z;
    coord_t     point_x;
    coord_t     point_y;
    coord_t     point_z;
  } in_t;

  typedef struct packed {
    logic        was_query;
    logic [3:0]  hit_count;
    logic [31:0] cell_size;
  } out_t;

  typedef struct packed {
    logic [1:0] kind;
    coord_t     lo_x;
    coord_t     hi_x;
    coord_t     lo_y;
    coord_t     hi_y;
    coord_t     lo_z;
    coord_t     hi_z;
  } region_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } tbl_ctl_t;

endpackage

// ----- hw/rtl/region_refinement_cell_size_top.sv -----
// Region refinement cell size block, top level: sequencer, squaring, scaling.
// Depends on rrcs_pkg, rrcs_table and region_refinement_cell_size_top_assert.svh.
//
// Usage:
//   Command channel: item is taken at a clock edge with start high and busy low.
//   opcode 0 loads region slot 'slot' (ignored past REGIONS, still acknowledged);
//   opcode 1 queries a point against all enabled regions.
//   Result channel: done is high for exactly one cycle with result valid; the
//   receiver cannot stall it. Write acknowledges carry zero count and size.
//   Config channel: cfg_data is written to the base spacing when cfg_valid and
//   cfg_ready are high; cfg_ready is always high. Write only while idle.
// Timing:
//   A write gives its result in the cycle after the accept; busy stays low.
//   A query passes through S_SQ (squares), S_SCAN (one read of the region memory
//   per slot), S_DRAIN and S_SCALE (scaling); the next item can be taken in the
//   result cycle.
// Reset: all regions disabled, base spacing 1.0 (Q16.16), no result pending.
`timescale 1ns / 1ps

module region_refinement_cell_size_top
  import rrcs_pkg::*;
#(
  parameter int REGIONS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  in_t         item,
  output logic        busy,
  output logic        done,
  output out_t        result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  `include "region_refinement_cell_size_top_assert.svh"

  localparam int AW = (REGIONS > 1) ? $clog2(REGIONS) : 1;
  localparam int HW = $clog2(REGIONS + 1);
  localparam int SQ = 2 * COORD_BITS;
  localparam logic [6:0]    REGIONS_W = 7'(REGIONS);
  localparam logic [AW-1:0] LAST_IDX  = AW'(REGIONS - 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SQ    = 5'b00010,
    S_SCAN  = 5'b00100,
    S_DRAIN = 5'b01000,
    S_SCALE = 5'b10000
  } state_t;

  state_t          state, state_next;
  logic [31:0]     base_spacing;
  coord_t          px, py, pz;
  logic [SQ-1:0]   sq_x, sq_y, sq_z;
  logic [SQ+1:0]   r2;
  logic [63:0]     recip_prod;
  logic [AW-1:0]   rd_idx;
  logic            p1_v, p2_v;
  logic [1:0]      b_kind;
  logic [SQ-1:0]   b_lo2, b_hi2;
  logic            b_box;
  logic [HW-1:0]   hits;
  logic            accept;
  logic [6:0]      slot_w;
  tbl_ctl_t        tbl_ctl;
  region_t         wr_entry;
  region_t         rd_entry;
  logic signed [SQ-1:0] lo2_s, hi2_s, sqx_s, sqy_s, sqz_s;
  logic            hit;
  logic [32:0]     scaled;
  logic [32:0]     shifted;
  logic [31:0]     cell_sat;

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign slot_w    = {4'b0, item.slot};

  assign tbl_ctl.wr_en = accept && (item.opcode == OP_WRITE) && (slot_w < REGIONS_W);
  assign tbl_ctl.rd_en = (state == S_SCAN);

  assign wr_entry = '{kind: item.kind, lo_x: item.lo_x, hi_x: item.hi_x,
                      lo_y: item.lo_y, hi_y: item.hi_y,
                      lo_z: item.lo_z, hi_z: item.hi_z};

  rrcs_table #(
    .REGIONS (REGIONS),
    .AW      (AW)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .ctl      (tbl_ctl),
    .wr_addr  (slot_w[AW-1:0]),
    .wr_entry (wr_entry),
    .rd_addr  (rd_idx),
    .rd_entry (rd_entry)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && item.opcode == OP_QUERY) begin
          state_next = S_SQ;
        end
      end
      S_SQ:    state_next = S_SCAN;
      S_SCAN: begin
        if (rd_idx == LAST_IDX) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!p1_v && !p2_v) begin
          state_next = S_SCALE;
        end
      end
      S_SCALE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      base_spacing <= SPACING_RESET;
      done         <= 1'b0;
      rd_idx       <= '0;
      p1_v         <= 1'b0;
      p2_v         <= 1'b0;
      hits         <= '0;
    end else begin
      state <= state_next;
      done  <= (accept && item.opcode == OP_WRITE) || (state == S_SCALE);
      if (cfg_valid && cfg_ready) begin
        base_spacing <= cfg_data;
      end
      p1_v <= tbl_ctl.rd_en;
      p2_v <= p1_v;
      if (state == S_SCAN) begin
        rd_idx <= rd_idx + AW'(1);
      end else begin
        rd_idx <= '0;
      end
      if (accept) begin
        hits <= '0;
      end else if (p2_v && hit) begin
        hits <= hits + HW'(1);
      end
    end
  end

  assign sqx_s = px * px;
  assign sqy_s = py * py;
  assign sqz_s = pz * pz;

  // point capture, squares, reciprocal product
  always_ff @(posedge clk) begin
    if (accept) begin
      px <= item.point_x;
      py <= item.point_y;
      pz <= item.point_z;
    end
    if (state == S_SQ) begin
      sq_x       <= $unsigned(sqx_s);
      sq_y       <= $unsigned(sqy_s);
      sq_z       <= $unsigned(sqz_s);
      recip_prod <= base_spacing * RECIP_10;
    end
    r2 <= {2'b0, sq_x} + {2'b0, sq_y} + {2'b0, sq_z};
  end

  assign lo2_s = rd_entry.lo_x * rd_entry.lo_x;
  assign hi2_s = rd_entry.hi_x * rd_entry.hi_x;

  // scan stage B: bound squares and box test
  always_ff @(posedge clk) begin
    b_kind <= rd_entry.kind;
    b_lo2  <= $unsigned(lo2_s);
    b_hi2  <= $unsigned(hi2_s);
    b_box  <= (px >= rd_entry.lo_x) && (px <= rd_entry.hi_x) &&
              (py >= rd_entry.lo_y) && (py <= rd_entry.hi_y) &&
              (pz >= rd_entry.lo_z) && (pz <= rd_entry.hi_z);
  end

  // scan stage C: hit decision
  always_comb begin
    case (b_kind)
      KIND_SHELL: hit = (r2 > {2'b0, b_lo2}) && (r2 < {2'b0, b_hi2});
      KIND_BOX:   hit = b_box;
      default:    hit = 1'b0;
    endcase
  end

  // dx*1.1 = dx + floor(dx/10) exactly under truncation
  assign scaled   = {1'b0, base_spacing} + 33'(recip_prod[63:RECIP_SHIFT]);
  assign shifted  = scaled >> hits;
  assign cell_sat = shifted[32] ? 32'hFFFF_FFFF : shifted[31:0];

  always_ff @(posedge clk) begin
    if (accept && item.opcode == OP_WRITE) begin
      result <= '0;
    end else if (state == S_SCALE) begin
      result.was_query <= 1'b1;
      result.hit_count <= (32'(hits) > 32'd15) ? 4'd15 : 4'(hits);
      result.cell_size <= cell_sat;
    end
  end

  `RRCS_ASSERT_NOW(a_done_idle, done, state == S_IDLE, "result while busy")
  `RRCS_ASSERT_NEXT(a_query_starts, accept && item.opcode == OP_QUERY,
                    state == S_SQ && !done, "query did not start")
  `RRCS_ASSERT_NOW(a_query_from_scale, done && result.was_query,
                   $past(state) == S_SCALE, "query result out of sequence")
  `RRCS_ASSERT_NOW(a_hits_bound, 1'b1, 32'(hits) <= REGIONS, "hit count beyond table")

endmodule

// ----- hw/rtl/rrcs_table.sv -----
// Region table: one write port, one registered read port.
// Per-slot valid bits make unwritten slots read as disabled. Uses rrcs_pkg.
`timescale 1ns / 1ps

module rrcs_table
  import rrcs_pkg::*;
#(
  parameter int REGIONS = 8,
  parameter int AW      = 3
) (
  input  logic          clk,
  input  logic          rst,
  input  tbl_ctl_t      ctl,
  input  logic [AW-1:0] wr_addr,
  input  region_t       wr_entry,
  input  logic [AW-1:0] rd_addr,
  output region_t       rd_entry
);

  region_t              mem [REGIONS];
  logic [REGIONS-1:0]   valid;
  region_t              rd_data;
  logic                 rd_valid;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  always_comb begin
    rd_entry = rd_data;
    if (!rd_valid) begin
      rd_entry.kind = KIND_OFF;
    end
  end

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking bench for region_refinement_cell_size_top: region loads and point queries
// are checked against an in-bench model of the region table and the cell size scaling.
// Depends on rrcs_pkg and the RTL of region_refinement_cell_size_top.
`timescale 1ns / 1ps

module tb;
  import rrcs_pkg::*;

  localparam int NUM_SLOTS = 8;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 250;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = NUM_SLOTS + 12;
  localparam int MAX_PRINTED = 40;
  localparam coord_t COORD_MIN = 24'h80_0000;
  localparam coord_t COORD_MAX = 24'h7F_FFFF;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  in_t         item = '0;
  logic        busy;
  logic        done;
  out_t        result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  region_refinement_cell_size_top #(.REGIONS(NUM_SLOTS)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .item(item),
    .busy(busy),
    .done(done),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  // model state, owned by the monitor
  region_t     table_model[NUM_SLOTS];
  logic [31:0] spacing_model = SPACING_RESET;
  out_t        expected_results[$];

  // generator-side copy of the table, tracks the order items are queued in
  region_t     table_plan[NUM_SLOTS];
  in_t         pending_items[$];

  logic        took = 1'b0;
  int unsigned gap_left = 0;
  int unsigned burst_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned n_loads = 0;
  int unsigned n_queries = 0;
  int unsigned n_spacings = 0;
  int unsigned n_saturated = 0;
  int unsigned top_hits = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (mismatches < MAX_PRINTED)
      $display("mismatch: %s got %0h expected %0h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  function automatic longint unsigned sq(input coord_t v);
    longint w;
    w = v;
    return w * w;
  endfunction

  function automatic out_t predict_cell(input in_t cmd);
    out_t            res;
    region_t         rg;
    longint unsigned r2;
    longint unsigned scaled;
    int unsigned     hits;
    res = '0;
    if (cmd.opcode == OP_WRITE) begin
      n_loads++;
      if (cmd.slot < NUM_SLOTS)
        table_model[cmd.slot] = '{kind: cmd.kind, lo_x: cmd.lo_x, hi_x: cmd.hi_x,
                                  lo_y: cmd.lo_y, hi_y: cmd.hi_y,
                                  lo_z: cmd.lo_z, hi_z: cmd.hi_z};
      return res;
    end
    n_queries++;
    r2 = sq(cmd.point_x) + sq(cmd.point_y) + sq(cmd.point_z);
    hits = 0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      rg = table_model[i];
      if (rg.kind == KIND_SHELL) begin
        if (r2 > sq(rg.lo_x) && r2 < sq(rg.hi_x)) hits++;
      end else if (rg.kind == KIND_BOX) begin
        if (cmd.point_x >= rg.lo_x && cmd.point_x <= rg.hi_x &&
            cmd.point_y >= rg.lo_y && cmd.point_y <= rg.hi_y &&
            cmd.point_z >= rg.lo_z && cmd.point_z <= rg.hi_z) hits++;
      end
    end
    scaled = (64'(spacing_model) * 64'd11) / 64'd10;
    scaled = (hits >= 64) ? 64'd0 : (scaled >> hits);
    res.was_query = 1'b1;
    res.hit_count = (hits > 15) ? 4'd15 : 4'(hits);
    res.cell_size = (scaled > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : scaled[31:0];
    if (res.cell_size == 32'hFFFF_FFFF) n_saturated++;
    if (hits > top_hits) top_hits = hits;
    return res;
  endfunction

  // gap after each item, with occasional back-to-back stretches
  function automatic int unsigned draw_gap();
    if (burst_left == 0 && $urandom_range(0, 15) == 0) burst_left = $urandom_range(10, 60);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || took) begin
      if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_items.size() > 0) begin
        item <= pending_items.pop_front();
        start <= 1'b1;
        gap_left <= draw_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    out_t want;
    if (rst) begin
      foreach (table_model[i]) table_model[i] = '0;
      spacing_model = SPACING_RESET;
      took <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      took <= start && !busy;
      if (done) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with nothing outstanding", result, 0);
        end else begin
          want = expected_results.pop_front();
          if (result.was_query !== want.was_query)
            report_mismatch("was_query", result.was_query, want.was_query);
          if (result.hit_count !== want.hit_count)
            report_mismatch("hit_count", result.hit_count, want.hit_count);
          if (result.cell_size !== want.cell_size)
            report_mismatch("cell_size", result.cell_size, want.cell_size);
        end
      end
      if (cfg_valid && cfg_ready) begin
        spacing_model = cfg_data;
        n_spacings++;
      end
      if (start && !busy) expected_results.push_back(predict_cell(item));
      quiet_cycles <= (done || (start && !busy) || (cfg_valid && cfg_ready)) ?
                      0 : quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic in_t noise_item();
    logic [223:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return raw[$bits(in_t)-1:0];
  endfunction

  function automatic coord_t span_coord(input int bits);
    coord_t c;
    c = coord_t'($urandom);
    return c >>> (COORD_BITS - bits);
  endfunction

  function automatic int pick_bits();
    case ($urandom_range(0, 3))
      0: return 4;
      1: return 10;
      2: return 17;
      default: return 24;
    endcase
  endfunction

  task automatic queue_write(input logic [2:0] slot, input logic [1:0] kind,
                             input coord_t lo_x, input coord_t hi_x, input coord_t lo_y,
                             input coord_t hi_y, input coord_t lo_z, input coord_t hi_z);
    in_t cmd;
    cmd = noise_item();
    cmd.opcode = OP_WRITE;
    cmd.slot = slot;
    cmd.kind = kind;
    cmd.lo_x = lo_x;
    cmd.hi_x = hi_x;
    cmd.lo_y = lo_y;
    cmd.hi_y = hi_y;
    cmd.lo_z = lo_z;
    cmd.hi_z = hi_z;
    table_plan[slot] = '{kind: kind, lo_x: lo_x, hi_x: hi_x, lo_y: lo_y, hi_y: hi_y,
                         lo_z: lo_z, hi_z: hi_z};
    pending_items.push_back(cmd);
  endtask

  task automatic queue_query(input coord_t px, input coord_t py, input coord_t pz);
    in_t cmd;
    cmd = noise_item();
    cmd.opcode = OP_QUERY;
    cmd.point_x = px;
    cmd.point_y = py;
    cmd.point_z = pz;
    pending_items.push_back(cmd);
  endtask

  task automatic queue_full_box(input logic [2:0] slot);
    queue_write(slot, KIND_BOX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX,
                COORD_MIN, COORD_MAX);
  endtask

  task automatic random_write();
    int         pick;
    int         bits;
    logic [1:0] kind;
    coord_t     a;
    coord_t     b;
    coord_t     lo[3];
    coord_t     hi[3];
    pick = $urandom_range(0, 19);
    kind = (pick < 2) ? KIND_OFF : (pick < 9) ? KIND_SHELL :
           (pick < 18) ? KIND_BOX : KIND_UNUSED;
    bits = pick_bits();
    for (int ax = 0; ax < 3; ax++) begin
      a = span_coord(bits);
      b = span_coord(bits);
      if ((kind == KIND_SHELL) ? (sq(a) <= sq(b)) : (a <= b)) begin
        lo[ax] = a;
        hi[ax] = b;
      end else begin
        lo[ax] = b;
        hi[ax] = a;
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      a = lo[0];
      lo[0] = hi[0];
      hi[0] = a;
    end
    queue_write(3'($urandom), kind, lo[0], hi[0], lo[1], hi[1], lo[2], hi[2]);
  endtask

  task automatic random_query();
    int      mode;
    int      ax;
    region_t rg;
    coord_t  p[3];
    coord_t  blo[3];
    coord_t  bhi[3];
    longint  span;
    longint  rlo;
    longint  rhi;
    longint  r;
    for (int i = 0; i < 3; i++) p[i] = span_coord(pick_bits());
    mode = $urandom_range(0, 9);
    rg = table_plan[$urandom_range(0, NUM_SLOTS - 1)];
    blo = '{rg.lo_x, rg.lo_y, rg.lo_z};
    bhi = '{rg.hi_x, rg.hi_y, rg.hi_z};
    if (mode < 4 && rg.kind == KIND_BOX && blo[0] <= bhi[0] && blo[1] <= bhi[1] &&
        blo[2] <= bhi[2]) begin
      for (int i = 0; i < 3; i++) begin
        span = longint'(bhi[i]) - longint'(blo[i]) + 1;
        case ($urandom_range(0, 5))
          0: p[i] = blo[i];
          1: p[i] = bhi[i];
          default: p[i] = coord_t'(longint'(blo[i]) + longint'($urandom) % span);
        endcase
      end
    end else if (mode < 7 && rg.kind == KIND_SHELL) begin
      rlo = (rg.lo_x < 0) ? -longint'(rg.lo_x) : longint'(rg.lo_x);
      rhi = (rg.hi_x < 0) ? -longint'(rg.hi_x) : longint'(rg.hi_x);
      if (rlo > rhi) begin
        r = rlo;
        rlo = rhi;
        rhi = r;
      end
      case ($urandom_range(0, 5))
        0: r = rlo;
        1: r = rhi;
        default: r = rlo + longint'($urandom) % (rhi - rlo + 1);
      endcase
      p = '{24'sd0, 24'sd0, 24'sd0};
      ax = $urandom_range(0, 2);
      p[ax] = (r > longint'(COORD_MAX) || $urandom_range(0, 1) == 1) ?
              coord_t'(-r) : coord_t'(r);
    end else if (mode == 9) begin
      for (int i = 0; i < 3; i++)
        case ($urandom_range(0, 4))
          0: p[i] = COORD_MIN;
          1: p[i] = COORD_MAX;
          2: p[i] = 24'sd0;
          3: p[i] = -24'sd1;
          default: p[i] = 24'sd1;
        endcase
    end
    queue_query(p[0], p[1], p[2]);
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || start || expected_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_spacing(input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [31:0] spacings[PHASES];
    int          full_slots[6];
    spacings = '{32'd1, 32'hFFFF_FFFF, $urandom, 32'h8000_0000, $urandom, SPACING_RESET,
                 32'd10, $urandom};
    full_slots = '{1, 2, 3, 4, 6, 7};
    foreach (table_plan[i]) table_plan[i] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // saturation with no hits, then one hit brings it in range
    write_spacing(32'hFFFF_FFFF);
    queue_query(24'sd0, 24'sd0, 24'sd0);
    queue_full_box(3'd0);
    queue_query(COORD_MIN, COORD_MIN, COORD_MIN);
    wait_idle();

    write_spacing(SPACING_RESET);
    queue_write(3'd1, KIND_SHELL, -24'sd1000, COORD_MIN, 24'sd0, 24'sd0, 24'sd0, 24'sd0);
    queue_write(3'd2, KIND_UNUSED, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX,
                COORD_MIN, COORD_MAX);
    queue_write(3'd3, KIND_BOX, 24'sd5, -24'sd5, COORD_MIN, COORD_MAX,
                COORD_MIN, COORD_MAX);
    queue_write(3'd4, KIND_SHELL, 24'sd2000, 24'sd1000, 24'sd0, 24'sd0, 24'sd0, 24'sd0);
    queue_query(COORD_MAX, COORD_MAX, COORD_MAX);
    queue_query(24'sd1000, 24'sd0, 24'sd0);
    queue_query(24'sd0, -24'sd1001, 24'sd0);
    queue_write(3'd5, KIND_BOX, -24'sd10, 24'sd10, -24'sd20, 24'sd20, -24'sd30, 24'sd30);
    queue_query(24'sd10, -24'sd20, 24'sd30);
    queue_query(-24'sd11, 24'sd0, 24'sd0);
    foreach (full_slots[i]) queue_full_box(3'(full_slots[i]));
    queue_query(24'sd0, 24'sd0, 24'sd0);
    queue_write(3'd7, KIND_OFF, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0);
    queue_query(COORD_MIN, COORD_MAX, 24'sd0);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      write_spacing(spacings[ph]);
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 3) == 0) random_write();
        else random_query();
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("results never delivered", expected_results.size(), 0);
    $display("covered %0d region loads and %0d point queries over %0d spacing settings",
             n_loads, n_queries, n_spacings);
    $display("deepest overlap %0d regions, %0d saturated cell sizes, %0d mismatches",
             top_hits, n_saturated, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
